>>> src/slid_pkg.sv
// Shared constants and types for the sorted list insert/delete block.
// No dependencies; every other file of the block refers to this package.
package slid_pkg;

   // List size and derived widths
   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Payload field widths
   localparam int VALUE_W  = 32;
   localparam int MOVES_W  = 5;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 5;

   // Operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;   // capture the accepted request
      logic scan;   // compare all entries and locate the position
      logic apply;  // shift entries, update count, load the result register
   } cmd_type;

endpackage

>>> src/slid_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on slid_pkg for field widths.
interface slid_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 op;
   logic signed [slid_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface slid_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [slid_pkg::MOVES_W-1:0]    moves;
   logic [slid_pkg::STATUS_W-1:0]   status;
   logic [slid_pkg::TOTAL_W-1:0]    entry_total;

   modport source (output valid, output moves, output status, output entry_total,
                   input ready);
   modport sink   (input valid, input moves, input status, input entry_total,
                   output ready);
endinterface

>>> src/slid_ctrl.sv
// Controller for the sorted list: sequences accept, scan and apply,
// and owns the response valid flag. Depends on slid_pkg.
module slid_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output slid_pkg::cmd_type cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Decode commands from the current state
   always_comb begin
      req_ready = (state_ff == S_IDLE);
      cmd.load  = req_valid && req_ready;
      cmd.scan  = (state_ff == S_SCAN);
      cmd.apply = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_ready);
   end

   // Advance the sequence; hold in apply while the result register is occupied
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (cmd.load) state_in = S_SCAN;
         S_SCAN:  state_in = S_APPLY;
         S_APPLY: if (cmd.apply) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Set valid when a result is loaded, drop it on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.apply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A result appears only out of the apply step
   a_valid_from_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_APPLY)
      else $error("response valid rose outside apply");

   // An accepted request is always scanned next
   a_accept_to_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_SCAN)
      else $error("accepted request not followed by scan");

endmodule

>>> src/slid_dpath.sv
// Datapath for the sorted list: entry cells, compare vector, position
// encoder, shift network, count and result register. Depends on slid_pkg.
module slid_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  slid_pkg::cmd_type                     cmd,
   input  logic                                  req_op,
   input  logic signed [slid_pkg::VALUE_W-1:0]   req_value,
   output logic [slid_pkg::MOVES_W-1:0]          rsp_moves,
   output logic [slid_pkg::STATUS_W-1:0]         rsp_status,
   output logic [slid_pkg::TOTAL_W-1:0]          rsp_entry_total
);

   localparam int CAP   = slid_pkg::CAPACITY;
   localparam int CNT_W = slid_pkg::CNT_W;

   logic                                 op_ff;
   logic signed [slid_pkg::VALUE_W-1:0]  value_ff;
   logic signed [slid_pkg::VALUE_W-1:0]  entries_ff [CAP];
   logic signed [slid_pkg::VALUE_W-1:0]  entries_in [CAP];
   logic [CNT_W-1:0]                     count_ff, count_in;
   logic [CNT_W-1:0]                     pos_ff, pos_in;
   logic                                 found_ff, found_in;
   logic [CAP-1:0]                       hit;
   logic                                 full;
   logic [slid_pkg::MOVES_W-1:0]         moves_ff, moves_in;
   logic [slid_pkg::STATUS_W-1:0]        status_ff, status_in;
   logic [slid_pkg::TOTAL_W-1:0]         total_ff, total_in;

   assign full = (count_ff == CNT_W'(CAP));

   // Compare every held entry with the value in parallel
   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         if (op_ff == slid_pkg::OP_INSERT) begin
            // first entry greater than the value, or past the end
            hit[i] = !((CNT_W'(i) < count_ff) && (entries_ff[i] <= value_ff));
         end else begin
            hit[i] = (CNT_W'(i) < count_ff) && (entries_ff[i] == value_ff);
         end
      end
   end

   // Encode the lowest hit into a position
   always_comb begin
      pos_in = count_ff;
      for (int i = CAP - 1; i >= 0; i--) begin
         if (hit[i]) pos_in = CNT_W'(i);
      end
      found_in = |hit;
   end

   // Shift the cells and compute the result fields
   always_comb begin
      entries_in = entries_ff;
      count_in   = count_ff;
      moves_in   = '0;
      status_in  = slid_pkg::STATUS_OK;
      if (op_ff == slid_pkg::OP_INSERT) begin
         if (full) begin
            status_in = slid_pkg::STATUS_FULL;
         end else begin
            for (int i = 0; i < CAP; i++) begin
               if (CNT_W'(i) == pos_ff) begin
                  entries_in[i] = value_ff;
               end else if (CNT_W'(i) > pos_ff && CNT_W'(i) <= count_ff) begin
                  entries_in[i] = entries_ff[(i == 0) ? 0 : i - 1];
               end
            end
            moves_in = slid_pkg::MOVES_W'(count_ff - pos_ff);
            count_in = count_ff + CNT_W'(1);
         end
      end else begin
         if (!found_ff) begin
            status_in = slid_pkg::STATUS_NOT_FOUND;
            moves_in  = slid_pkg::MOVES_W'(count_ff);
         end else begin
            for (int i = 0; i < CAP; i++) begin
               if (CNT_W'(i) >= pos_ff && CNT_W'(i) + CNT_W'(1) < count_ff) begin
                  entries_in[i] = entries_ff[(i == CAP - 1) ? i : i + 1];
               end
            end
            moves_in = slid_pkg::MOVES_W'(count_ff - CNT_W'(1) - pos_ff);
            count_in = count_ff - CNT_W'(1);
         end
      end
      total_in = slid_pkg::TOTAL_W'(count_in);
   end

   // Count is control state and resets; payload registers do not
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.apply) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         value_ff <= req_value;
      end
      if (cmd.scan) begin
         pos_ff   <= pos_in;
         found_ff <= found_in;
      end
      if (cmd.apply) begin
         entries_ff <= entries_in;
         moves_ff   <= moves_in;
         status_ff  <= status_in;
         total_ff   <= total_in;
      end
   end

   assign rsp_moves       = moves_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_total = total_ff;

   // The count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAP))
      else $error("entry count above capacity");

   // A successful insert grows the list by exactly one
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.apply && op_ff == slid_pkg::OP_INSERT && !full
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the list by one");

   // Held entries stay in ascending order
   for (genvar g = 0; g < CAP - 1; g++) begin : g_order
      a_sorted: assert property (@(posedge clock) disable iff (reset)
         (CNT_W'(g + 1) < count_ff) |-> (entries_ff[g] <= entries_ff[g + 1]))
         else $error("held entries out of order");
   end

endmodule

>>> src/sorted_list_insert_delete.sv
// Sorted list insert/delete: holds up to slid_pkg::CAPACITY signed 32-bit
// values in ascending order. Each request passes through the transfer
// into the block, a scan cycle that compares all entries with the value at
// once and encodes the position, and an apply cycle that shifts the entry
// cells and loads the result register. The apply cycle waits while an
// earlier result is still not taken; the next request is accepted the cycle
// after apply, so a new request is not taken until the last one is applied.
// Entries have no reset; in the datapath only the count is cleared.
module sorted_list_insert_delete (
   input  logic           clock,
   input  logic           reset,
   slid_req_if.sink       req_chan,
   slid_rsp_if.source     rsp_chan
);

   slid_pkg::cmd_type cmd;
   logic              req_ready;
   logic              rsp_valid;

   // Sequence the request through scan and apply
   slid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // Hold the list and build the result
   slid_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_op          (req_chan.op),
      .req_value       (req_chan.value),
      .rsp_moves       (rsp_chan.moves),
      .rsp_status      (rsp_chan.status),
      .rsp_entry_total (rsp_chan.entry_total)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

endmodule

>>> tb/slid_scoreboard_pkg.sv
// Scoreboard for the sorted list insert/delete testbench: a shadow copy of
// the list that predicts each response and checks the ones that come back.
// Depends on slid_pkg for widths, operation codes and status codes.
package slid_scoreboard_pkg;
   import slid_pkg::*;

   typedef struct packed {
      logic [MOVES_W-1:0]  moves;
      logic [STATUS_W-1:0] status;
      logic [TOTAL_W-1:0]  entry_total;
   } list_result_t;

   class list_scoreboard;
      logic signed [VALUE_W-1:0] shadow_list [CAPACITY];
      int                        held;
      list_result_t              due_q [$];
      int                        errors;

      function new();
         held   = 0;
         errors = 0;
      endfunction

      // Apply one accepted request to the shadow list and queue its response
      function void note_request(logic op, logic signed [VALUE_W-1:0] value);
         list_result_t res;
         int           pos;
         res = '0;
         pos = 0;
         if (op == OP_INSERT) begin
            if (held >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               // land after every entry not greater than the value
               while (pos < held && shadow_list[pos] <= value) pos++;
               for (int i = held; i > pos; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[pos] = value;
               res.moves        = MOVES_W'(held - pos);
               held++;
            end
         end else begin
            // remove the lowest-placed equal entry, if any
            while (pos < held && shadow_list[pos] != value) pos++;
            if (pos == held) begin
               res.status = STATUS_NOT_FOUND;
               res.moves  = MOVES_W'(held);
            end else begin
               for (int i = pos; i + 1 < held; i++) shadow_list[i] = shadow_list[i+1];
               res.moves = MOVES_W'(held - 1 - pos);
               held--;
            end
         end
         res.entry_total = TOTAL_W'(held);
         due_q.push_back(res);
      endfunction

      function int pending();
         return due_q.size();
      endfunction

      // Compare one accepted response with the oldest prediction
      function void check_response(logic [MOVES_W-1:0] moves, logic [STATUS_W-1:0] status,
                                   logic [TOTAL_W-1:0] entry_total);
         list_result_t want;
         if (due_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected response: moves %0d status %0d total %0d",
                        moves, status, entry_total);
            return;
         end
         want = due_q.pop_front();
         if (want.moves !== moves || want.status !== status ||
             want.entry_total !== entry_total) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: moves %0d/%0d status %0d/%0d total %0d/%0d (want/got)",
                        want.moves, moves, want.status, status,
                        want.entry_total, entry_total);
         end
      endfunction
   endclass

endpackage

>>> tb/sorted_list_insert_delete_test.sv
// Top-level testbench for sorted_list_insert_delete: drives insert and delete
// requests under varying idle/stall patterns and checks every response.
// Depends on slid_pkg, the channel interfaces and slid_scoreboard_pkg.
module sorted_list_insert_delete_test;
   timeunit 1ns;
   timeprecision 1ps;

   import slid_pkg::*;
   import slid_scoreboard_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int SEGMENTS    = 17;
   localparam int SEG_ITEMS   = 100;

   logic clock;
   logic reset;

   slid_req_if req_chan ();
   slid_rsp_if rsp_chan ();

   sorted_list_insert_delete u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   list_scoreboard sb = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int holds_asked    = 0;
   int holds_taken    = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;

   // Free-running clock, 10 ns period
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Feed accepted transfers to the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_request(req_chan.op, req_chan.value);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_response(rsp_chan.moves, rsp_chan.status, rsp_chan.entry_total);
      end
   end

   // Drive response ready: random stalls, plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (holds_taken != holds_asked) begin
         holds_taken = holds_taken + 1;
         hold_left   = HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Abort if nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Offer one request, after a random idle gap, and hold it until transferred
   task automatic send_op(logic op, logic signed [VALUE_W-1:0] value);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op    <= op;
      req_chan.value <= value;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Drop the request valid and wait until every predicted response is back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin
      logic signed [VALUE_W-1:0] value_pool [$];
      logic signed [VALUE_W-1:0] val;
      logic                      op;
      int                        insert_pct;
      int                        bias_left;
      int                        mode;

      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.op    <= OP_INSERT;
      req_chan.value <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty delete, extremes, duplicates, front/back placement
      send_op(OP_DELETE, 32'sd0);
      send_op(OP_INSERT, 32'sd0);
      send_op(OP_INSERT, 32'sh7fffffff);
      send_op(OP_INSERT, 32'sh80000000);
      send_op(OP_INSERT, -32'sd1);
      send_op(OP_INSERT, 32'sd0);
      send_op(OP_INSERT, 32'sd1);
      send_op(OP_DELETE, 32'sd0);
      send_op(OP_DELETE, 32'sd5);
      send_op(OP_DELETE, 32'sh7fffffff);
      send_op(OP_DELETE, 32'sh80000000);
      // fill to capacity, each new value landing at the front
      for (int i = 0; i < CAPACITY - 3; i++) send_op(OP_INSERT, -32'sd10 - i);
      send_op(OP_INSERT, 32'sd5);
      send_op(OP_DELETE, -32'sd22);
      send_op(OP_DELETE, 32'sd123);
      send_op(OP_INSERT, 32'sh7fffffff);

      // Random: drift between empty and full with mostly known values
      insert_pct = 80;
      bias_left  = 30;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg % 3 == 0) wait_drained();
         case (seg % 5)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            3: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         // back up the block with a long receiver hold-off
         if (seg == 4) holds_asked++;
         for (int k = 0; k < SEG_ITEMS; k++) begin
            if (bias_left == 0) begin
               insert_pct = (insert_pct == 80) ? 20 : 80;
               bias_left  = $urandom_range(25, 60);
            end
            bias_left--;
            op   = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_DELETE;
            mode = $urandom_range(9);
            if (op == OP_DELETE && value_pool.size() != 0 && mode >= 3)
               mode = 9;
            case (mode)
               0, 1: val = $urandom;
               2: begin
                  case ($urandom_range(3))
                     0: val = 32'sh80000000;
                     1: val = 32'sh7fffffff;
                     2: val = 32'sd0;
                     default: val = -32'sd1;
                  endcase
               end
               3, 4, 5: val = $signed($urandom_range(20)) - 32'sd10;
               default: begin
                  if (value_pool.size() != 0)
                     val = value_pool[$urandom_range(value_pool.size() - 1)];
                  else
                     val = $signed($urandom_range(20)) - 32'sd10;
               end
            endcase
            if (op == OP_INSERT) begin
               value_pool.push_back(val);
               if (value_pool.size() > 24) void'(value_pool.pop_front());
            end
            send_op(op, val);
         end
      end

      // Drain and report
      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> filelist.f
src/slid_pkg.sv
src/slid_if.sv
src/slid_ctrl.sv
src/slid_dpath.sv
src/sorted_list_insert_delete.sv
tb/slid_scoreboard_pkg.sv
tb/sorted_list_insert_delete_test.sv
